FILE: rtl/aff_trs_pkg.sv
package aff_trs_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int SINCOS_BITS_DEF = 16;

    // Pipeline layout: stage 0 takes the beat, stages 1..13 are the sine/cosine
    // unit, 14..18 build and compose the matrix, 18 is the output register.
    localparam int N_STAGES  = 19;
    localparam int SC_STAGES = 13;
    localparam int SC_LAST   = 13;

    localparam int unsigned FULL_TURN    = 23040;
    localparam int unsigned QUARTER_TURN = 5760;
    localparam int unsigned EIGHTH_TURN  = 2880;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned RAD_DEN = 64'd11520;
    // u * PI / 11520 is split into an integer part and a small remainder term.
    localparam longint unsigned X_Q = PI_Q30 / RAD_DEN;
    localparam longint unsigned X_R = PI_Q30 % RAD_DEN;

    // Exact floor division by a constant: floor(y * ceil(2^(N+L)/k) / 2^(N+L)).
    localparam longint unsigned RCP_45 = ((64'd1 << 23) + 64'd44) / 64'd45;
    localparam int unsigned     SH_45  = 23;

    localparam longint unsigned RCP_72 = ((64'd1 << 37) + 64'd71) / 64'd72;
    localparam longint unsigned RCP_42 = ((64'd1 << 36) + 64'd41) / 64'd42;
    localparam longint unsigned RCP_20 = ((64'd1 << 35) + 64'd19) / 64'd20;
    localparam longint unsigned RCP_6  = ((64'd1 << 33) + 64'd5) / 64'd6;
    localparam longint unsigned RCP_90 = ((64'd1 << 37) + 64'd89) / 64'd90;
    localparam longint unsigned RCP_56 = ((64'd1 << 36) + 64'd55) / 64'd56;
    localparam longint unsigned RCP_30 = ((64'd1 << 35) + 64'd29) / 64'd30;
    localparam longint unsigned RCP_12 = ((64'd1 << 34) + 64'd11) / 64'd12;

    localparam longint unsigned RCP_SIN [4] = '{RCP_72, RCP_42, RCP_20, RCP_6};
    localparam int unsigned     SH_SIN  [4] = '{37, 36, 35, 33};
    localparam longint unsigned RCP_COS [4] = '{RCP_90, RCP_56, RCP_30, RCP_12};
    localparam int unsigned     SH_COS  [4] = '{37, 36, 35, 34};

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    typedef struct packed {
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic               use_parent;
        logic signed [31:0] parent_a;
        logic signed [31:0] parent_b;
        logic signed [31:0] parent_c;
        logic signed [31:0] parent_d;
        logic signed [31:0] parent_e;
        logic signed [31:0] parent_f;
    } t_pass;

    function automatic logic [29:0] div_rcp(logic [29:0] y, logic [30:0] m,
                                            int unsigned sh);
        logic [60:0] p;
        p = 61'(y) * 61'(m);
        return 30'(p >> sh);
    endfunction

    // Returns {clipped, value}.
    function automatic logic [32:0] sat32(logic signed [71:0] v);
        logic [32:0] res;
        if (v > 72'sd2147483647) begin
            res = {1'b1, 32'h7fff_ffff};
        end else if (v < -72'sd2147483648) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

endpackage

FILE: rtl/aff_trs_sincos.sv
module aff_trs_sincos #(
    parameter int SINCOS_BITS = aff_trs_pkg::SINCOS_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic [aff_trs_pkg::SC_STAGES-1:0] i_en,
    input  logic [14:0]                   i_r,
    output logic signed [SINCOS_BITS+1:0] o_sin,
    output logic signed [SINCOS_BITS+1:0] o_cos
);

    // Stage k of the block loads on i_en[k-1].
    logic [11:0] r_u1;
    logic [1:0]  r_q  [1:12];
    logic        r_sw [1:12];
    logic [29:0] r_xa2;
    logic [16:0] r_xb2;
    logic [29:0] r_x  [3:11];
    logic [29:0] r_x2 [4:11];
    logic [30:0] r_ts [4];
    logic [30:0] r_tc [4];
    logic [29:0] r_ps [3];
    logic [29:0] r_pc [3];
    logic [29:0] r_sf12;
    logic [29:0] r_pc12;

    logic [12:0] w1;
    logic [1:0]  q1;

    always_comb begin
        priority if (i_r >= 15'(3 * aff_trs_pkg::QUARTER_TURN)) begin
            q1 = 2'd3;
        end else if (i_r >= 15'(2 * aff_trs_pkg::QUARTER_TURN)) begin
            q1 = 2'd2;
        end else if (i_r >= 15'(aff_trs_pkg::QUARTER_TURN)) begin
            q1 = 2'd1;
        end else begin
            q1 = 2'd0;
        end
        w1 = 13'(i_r - 15'(q1) * 15'(aff_trs_pkg::QUARTER_TURN));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_q[1]  <= q1;
            r_sw[1] <= (w1 > 13'(aff_trs_pkg::EIGHTH_TURN));
            r_u1    <= (w1 > 13'(aff_trs_pkg::EIGHTH_TURN))
                       ? 12'(13'(aff_trs_pkg::QUARTER_TURN) - w1) : 12'(w1);
        end
        if (i_en[1]) begin
            r_xa2 <= 30'(31'(r_u1) * 31'(aff_trs_pkg::X_Q));
            r_xb2 <= 17'((25'(r_u1) * 25'(aff_trs_pkg::X_R)) >> 8);
        end
        if (i_en[2]) begin
            r_x[3] <= r_xa2 + 30'((35'(r_xb2) * 35'(aff_trs_pkg::RCP_45))
                                  >> aff_trs_pkg::SH_45);
        end
        if (i_en[3]) begin
            r_x2[4] <= 30'((60'(r_x[3]) * 60'(r_x[3])) >> 30);
        end
        if (i_en[4]) begin
            r_ts[0] <= aff_trs_pkg::ONE_Q30 - 31'(aff_trs_pkg::div_rcp(r_x2[4],
                           31'(aff_trs_pkg::RCP_SIN[0]), aff_trs_pkg::SH_SIN[0]));
            r_tc[0] <= aff_trs_pkg::ONE_Q30 - 31'(aff_trs_pkg::div_rcp(r_x2[4],
                           31'(aff_trs_pkg::RCP_COS[0]), aff_trs_pkg::SH_COS[0]));
        end
        if (i_en[11]) begin
            r_sf12 <= 30'((61'(r_x[11]) * 61'(r_ts[3])) >> 30);
            r_pc12 <= 30'((61'(r_x2[11]) * 61'(r_tc[3])) >> 30);
        end
    end

    genvar g;
    generate
        for (g = 2; g <= 12; g++) begin : g_ctl
            always_ff @(posedge i_clk) begin
                if (i_en[g-1]) begin
                    r_q[g]  <= r_q[g-1];
                    r_sw[g] <= r_sw[g-1];
                end
            end
        end
        for (g = 4; g <= 11; g++) begin : g_x
            always_ff @(posedge i_clk) begin
                if (i_en[g-1]) begin
                    r_x[g] <= r_x[g-1];
                end
            end
        end
        for (g = 5; g <= 11; g++) begin : g_x2
            always_ff @(posedge i_clk) begin
                if (i_en[g-1]) begin
                    r_x2[g] <= r_x2[g-1];
                end
            end
        end
        // Horner step: a multiply stage, then a constant-division stage.
        for (g = 0; g < 3; g++) begin : g_horner
            always_ff @(posedge i_clk) begin
                if (i_en[5+2*g]) begin
                    r_ps[g] <= 30'((61'(r_x2[6+2*g-1]) * 61'(r_ts[g])) >> 30);
                    r_pc[g] <= 30'((61'(r_x2[6+2*g-1]) * 61'(r_tc[g])) >> 30);
                end
                if (i_en[6+2*g]) begin
                    r_ts[g+1] <= aff_trs_pkg::ONE_Q30 - 31'(aff_trs_pkg::div_rcp(r_ps[g],
                                   31'(aff_trs_pkg::RCP_SIN[g+1]),
                                   aff_trs_pkg::SH_SIN[g+1]));
                    r_tc[g+1] <= aff_trs_pkg::ONE_Q30 - 31'(aff_trs_pkg::div_rcp(r_pc[g],
                                   31'(aff_trs_pkg::RCP_COS[g+1]),
                                   aff_trs_pkg::SH_COS[g+1]));
                end
            end
        end
    endgenerate

    logic [30:0]                   c_t;
    logic [30:0]                   s_rnd;
    logic [30:0]                   c_rnd;
    logic signed [SINCOS_BITS+1:0] s_oct;
    logic signed [SINCOS_BITS+1:0] c_oct;
    logic signed [SINCOS_BITS+1:0] s0;
    logic signed [SINCOS_BITS+1:0] c0;
    logic signed [SINCOS_BITS+1:0] n_sin;
    logic signed [SINCOS_BITS+1:0] n_cos;

    always_comb begin
        c_t   = aff_trs_pkg::ONE_Q30 - 31'(r_pc12 >> 1);
        s_rnd = (31'(r_sf12) + (31'd1 << (29 - SINCOS_BITS))) >> (30 - SINCOS_BITS);
        c_rnd = (c_t + (31'd1 << (29 - SINCOS_BITS))) >> (30 - SINCOS_BITS);
        s_oct = (SINCOS_BITS+2)'(s_rnd);
        c_oct = (SINCOS_BITS+2)'(c_rnd);
        // Past the octant midpoint the polynomials ran on the complement angle.
        s0 = r_sw[12] ? c_oct : s_oct;
        c0 = r_sw[12] ? s_oct : c_oct;
        unique case (r_q[12])
            2'd0: begin n_sin = s0;  n_cos = c0;  end
            2'd1: begin n_sin = c0;  n_cos = -s0; end
            2'd2: begin n_sin = -s0; n_cos = -c0; end
            default: begin n_sin = -c0; n_cos = s0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[aff_trs_pkg::SC_STAGES-1]) begin
            o_sin <= n_sin;
            o_cos <= n_cos;
        end
    end

endmodule

FILE: rtl/affine_trs_matrix_compose_unit.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+-----------------------------------------------
// input    | i_valid / o_stall  | i_scale_x/y, i_angle, i_trans_x/y, i_use_parent,
//          |                    | i_parent_a..i_parent_f
// output   | o_valid / i_stall  | o_out_a..o_out_f, o_saturated
//
// One beat per cycle sustained while i_stall is low; o_valid rises once a beat has
// passed the 19 register stages (stage 0 loads at the accepting edge; sine/cosine polynomial
// chain and matrix multiply follow).
// Reset is synchronous and clears only the stage valid bits.
// Every stage holds when it is full and the stage after it holds, so empty stages
// keep absorbing beats while the output waits; nothing is dropped or repeated.
module affine_trs_matrix_compose_unit #(
    parameter int FRAC_BITS   = aff_trs_pkg::FRAC_BITS_DEF,
    parameter int SINCOS_BITS = aff_trs_pkg::SINCOS_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_scale_x,
    input  logic signed [31:0] i_scale_y,
    input  logic signed [15:0] i_angle,
    input  logic signed [31:0] i_trans_x,
    input  logic signed [31:0] i_trans_y,
    input  logic               i_use_parent,
    input  logic signed [31:0] i_parent_a,
    input  logic signed [31:0] i_parent_b,
    input  logic signed [31:0] i_parent_c,
    input  logic signed [31:0] i_parent_d,
    input  logic signed [31:0] i_parent_e,
    input  logic signed [31:0] i_parent_f,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_out_a,
    output logic signed [31:0] o_out_b,
    output logic signed [31:0] o_out_c,
    output logic signed [31:0] o_out_d,
    output logic signed [31:0] o_out_e,
    output logic signed [31:0] o_out_f,
    output logic               o_saturated
);

    localparam int N  = aff_trs_pkg::N_STAGES;
    localparam int PW = 34 + SINCOS_BITS;

    logic [N-1:0] r_v;
    logic [N-1:0] en;

    always_comb begin
        en[N-1] = !r_v[N-1] || !i_stall;
        for (int k = N - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[N-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < N; k++) begin
                if (en[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // Payload that rides along until the composition stages need it.
    aff_trs_pkg::t_pass r_pass [0:17];
    logic [14:0]        r_ang0;
    logic signed [17:0] ang_v;
    logic [17:0]        ang_r;

    always_comb begin
        ang_v = 18'(i_angle) + 18'sd46080;
        priority if (ang_v >= 18'sd69120) begin
            ang_r = 18'(ang_v - 18'sd69120);
        end else if (ang_v >= 18'sd46080) begin
            ang_r = 18'(ang_v - 18'sd46080);
        end else if (ang_v >= 18'sd23040) begin
            ang_r = 18'(ang_v - 18'sd23040);
        end else begin
            ang_r = 18'(ang_v);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_ang0              <= ang_r[14:0];
            r_pass[0].scale_x   <= i_scale_x;
            r_pass[0].scale_y   <= i_scale_y;
            r_pass[0].trans_x   <= i_trans_x;
            r_pass[0].trans_y   <= i_trans_y;
            r_pass[0].use_parent <= i_use_parent;
            r_pass[0].parent_a  <= i_parent_a;
            r_pass[0].parent_b  <= i_parent_b;
            r_pass[0].parent_c  <= i_parent_c;
            r_pass[0].parent_d  <= i_parent_d;
            r_pass[0].parent_e  <= i_parent_e;
            r_pass[0].parent_f  <= i_parent_f;
        end
    end

    genvar g;
    generate
        for (g = 1; g <= 17; g++) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (en[g]) begin
                    r_pass[g] <= r_pass[g-1];
                end
            end
        end
    endgenerate

    logic signed [SINCOS_BITS+1:0] sin_v;
    logic signed [SINCOS_BITS+1:0] cos_v;

    aff_trs_sincos #(
        .SINCOS_BITS(SINCOS_BITS)
    ) u_sincos (
        .i_clk (i_clk),
        .i_en  (en[aff_trs_pkg::SC_LAST:1]),
        .i_r   (r_ang0),
        .o_sin (sin_v),
        .o_cos (cos_v)
    );

    // Stage 14: local rotation-scale products.
    logic signed [PW-1:0] r_p14 [4];
    logic signed [SINCOS_BITS+1:0] nsin;
    assign nsin = -sin_v;

    always_ff @(posedge i_clk) begin
        if (en[14]) begin
            r_p14[0] <= PW'(r_pass[13].scale_x) * PW'(cos_v);
            r_p14[1] <= PW'(r_pass[13].scale_y) * PW'(nsin);
            r_p14[2] <= PW'(r_pass[13].scale_x) * PW'(sin_v);
            r_p14[3] <= PW'(r_pass[13].scale_y) * PW'(cos_v);
        end
    end

    // Stage 15: round and clip the local matrix.
    logic [32:0] loc_sat [4];
    logic signed [31:0] r_m15 [6];
    logic signed [31:0] r_m16 [6];
    logic signed [31:0] r_m17 [6];
    logic r_f15;
    logic r_f16;
    logic r_f17;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            loc_sat[i] = aff_trs_pkg::sat32((72'(r_p14[i])
                         + (72'sd1 <<< (SINCOS_BITS - 1))) >>> SINCOS_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[15]) begin
            r_m15[0] <= loc_sat[0][31:0];
            r_m15[1] <= loc_sat[1][31:0];
            r_m15[2] <= r_pass[14].trans_x;
            r_m15[3] <= loc_sat[2][31:0];
            r_m15[4] <= loc_sat[3][31:0];
            r_m15[5] <= r_pass[14].trans_y;
            r_f15    <= loc_sat[0][32] | loc_sat[1][32] | loc_sat[2][32] | loc_sat[3][32];
        end
        if (en[16]) begin
            r_m16 <= r_m15;
            r_f16 <= r_f15;
        end
        if (en[17]) begin
            r_m17 <= r_m16;
            r_f17 <= r_f16;
        end
    end

    // Stage 16: parent products, two per entry (row term times column).
    logic signed [63:0] r_pp16 [6][2];

    always_ff @(posedge i_clk) begin
        if (en[16]) begin
            for (int j = 0; j < 3; j++) begin
                r_pp16[j][0]   <= 64'(r_pass[15].parent_a) * 64'(r_m15[j]);
                r_pp16[j][1]   <= 64'(r_pass[15].parent_b) * 64'(r_m15[j+3]);
                r_pp16[j+3][0] <= 64'(r_pass[15].parent_d) * 64'(r_m15[j]);
                r_pp16[j+3][1] <= 64'(r_pass[15].parent_e) * 64'(r_m15[j+3]);
            end
        end
    end

    // Stage 17: exact sums with the parent translation and rounding half.
    logic signed [66:0] r_sum17 [6];
    logic signed [31:0] kterm [6];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            kterm[i] = '0;
        end
        kterm[2] = r_pass[16].parent_c;
        kterm[5] = r_pass[16].parent_f;
    end

    always_ff @(posedge i_clk) begin
        if (en[17]) begin
            for (int i = 0; i < 6; i++) begin
                r_sum17[i] <= 67'(72'(r_pp16[i][0]) + 72'(r_pp16[i][1])
                              + (72'(kterm[i]) <<< FRAC_BITS)
                              + (72'sd1 <<< (FRAC_BITS - 1)));
            end
        end
    end

    // Stage 18: output register.
    logic [32:0]        cmp_sat [6];
    logic signed [31:0] r_out [6];
    logic               r_sat_out;
    logic               cmp_any;

    always_comb begin
        cmp_any = 1'b0;
        for (int i = 0; i < 6; i++) begin
            cmp_sat[i] = aff_trs_pkg::sat32(72'(r_sum17[i]) >>> FRAC_BITS);
            cmp_any    = cmp_any | cmp_sat[i][32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[18]) begin
            for (int i = 0; i < 6; i++) begin
                r_out[i] <= r_pass[17].use_parent ? cmp_sat[i][31:0] : r_m17[i];
            end
            r_sat_out <= r_f17 | (r_pass[17].use_parent & cmp_any);
        end
    end

    assign o_out_a     = r_out[0];
    assign o_out_b     = r_out[1];
    assign o_out_c     = r_out[2];
    assign o_out_d     = r_out[3];
    assign o_out_e     = r_out[4];
    assign o_out_f     = r_out[5];
    assign o_saturated = r_sat_out;

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_v && i_stall) |-> o_stall)
        else $error("full pipeline with a stalled output must stall the input");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v[0])
        else $error("accepted beat did not enter the first stage");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !r_v[N-2]) |=> !o_valid)
        else $error("output beat repeated after it was taken");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_v == '0))
        else $error("reset left a stage valid");

endmodule

FILE: sim/affine_trs_matrix_compose_unit_test.sv
module affine_trs_matrix_compose_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = aff_trs_pkg::FRAC_BITS_DEF;
    localparam int SCB  = aff_trs_pkg::SINCOS_BITS_DEF;
    localparam int N_RANDOM = 900;
    localparam int N_DIRECTED = 14;
    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] scale_x, scale_y;
        logic signed [15:0] angle;
        logic signed [31:0] trans_x, trans_y;
        logic               use_parent;
        logic signed [31:0] pa, pb, pc, pd, pe, pf;
    } t_xform;

    typedef struct {
        logic signed [31:0] m [6];
        logic               sat;
    } t_matrix;

    typedef struct {
        t_xform  x;
        bit      typed;
        t_matrix want;
    } t_vector_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid, o_saturated;
    logic signed [31:0] i_scale_x = '0, i_scale_y = '0, i_trans_x = '0, i_trans_y = '0;
    logic signed [15:0] i_angle = '0;
    logic i_use_parent = 1'b0;
    logic signed [31:0] i_parent_a = '0, i_parent_b = '0, i_parent_c = '0;
    logic signed [31:0] i_parent_d = '0, i_parent_e = '0, i_parent_f = '0;
    logic signed [31:0] o_out_a, o_out_b, o_out_c, o_out_d, o_out_e, o_out_f;

    t_matrix pending_matrices [$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit stim_done = 1'b0;

    always #5 i_clk = ~i_clk;

    affine_trs_matrix_compose_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_scale_x(i_scale_x), .i_scale_y(i_scale_y), .i_angle(i_angle),
        .i_trans_x(i_trans_x), .i_trans_y(i_trans_y), .i_use_parent(i_use_parent),
        .i_parent_a(i_parent_a), .i_parent_b(i_parent_b), .i_parent_c(i_parent_c),
        .i_parent_d(i_parent_d), .i_parent_e(i_parent_e), .i_parent_f(i_parent_f),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_out_a(o_out_a), .o_out_b(o_out_b), .o_out_c(o_out_c),
        .o_out_d(o_out_d), .o_out_e(o_out_e), .o_out_f(o_out_f),
        .o_saturated(o_saturated)
    );

    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint round_shift(longint v, int n);
        return (v + (64'sd1 << (n - 1))) >>> n;
    endfunction

    function automatic longint clip32(longint v, ref logic flag);
        if (v > I32_MAX) begin
            flag = 1'b1;
            return I32_MAX;
        end
        if (v < I32_MIN) begin
            flag = 1'b1;
            return I32_MIN;
        end
        return v;
    endfunction

    function automatic longint q30_to_sc(longint unsigned v);
        return longint'((v + (64'd1 << (29 - SCB))) >> (30 - SCB));
    endfunction

    // Taylor series on one octant, Q30 internally.
    function automatic void octant_trig(int unsigned u, output longint s, output longint c);
        longint unsigned x, x2, t;
        longint unsigned sin_div [4] = '{72, 42, 20, 6};
        longint unsigned cos_div [5] = '{90, 56, 30, 12, 2};
        x = (longint'(u) * 64'd3373259426) / 64'd11520;
        x2 = (x * x) >> 30;
        t = 64'd1 << 30;
        for (int i = 0; i < 4; i++) begin
            t = (64'd1 << 30) - (((x2 * t) >> 30) / sin_div[i]);
        end
        s = q30_to_sc((x * t) >> 30);
        t = 64'd1 << 30;
        for (int i = 0; i < 5; i++) begin
            t = (64'd1 << 30) - (((x2 * t) >> 30) / cos_div[i]);
        end
        c = q30_to_sc(t);
    endfunction

    function automatic void angle_trig(logic signed [15:0] ang, output longint s,
                                       output longint c);
        longint r, s0, c0;
        int unsigned quad, w;
        r = ((longint'(ang) % 23040) + 23040) % 23040;
        quad = r / 5760;
        w = r % 5760;
        if (w <= 2880) begin
            octant_trig(w, s0, c0);
        end else begin
            octant_trig(5760 - w, c0, s0);
        end
        case (quad)
            0: begin s = s0; c = c0; end
            1: begin s = c0; c = -s0; end
            2: begin s = -s0; c = -c0; end
            default: begin s = -c0; c = s0; end
        endcase
    endfunction

    // Exact (p1 + p2) >> FRAC rounded, plus k, without 64-bit overflow.
    function automatic longint sum_products(longint p1, longint p2, longint k);
        longint h1, h2, lo;
        h1 = floor_shift(p1, FRAC);
        h2 = floor_shift(p2, FRAC);
        lo = (p1 - (h1 <<< FRAC)) + (p2 - (h2 <<< FRAC));
        return h1 + h2 + k + round_shift(lo, FRAC);
    endfunction

    function automatic t_matrix compose_trs(t_xform x);
        t_matrix res;
        longint s, c, sx, sy, pa, pb, pc, pd, pe, pf;
        longint m [6];
        longint r [6];
        logic flag;
        flag = 1'b0;
        sx = x.scale_x; sy = x.scale_y;
        angle_trig(x.angle, s, c);
        m[0] = clip32(round_shift(sx * c, SCB), flag);
        m[1] = clip32(round_shift(sy * (-s), SCB), flag);
        m[2] = x.trans_x;
        m[3] = clip32(round_shift(sx * s, SCB), flag);
        m[4] = clip32(round_shift(sy * c, SCB), flag);
        m[5] = x.trans_y;
        if (x.use_parent) begin
            pa = x.pa; pb = x.pb; pc = x.pc; pd = x.pd; pe = x.pe; pf = x.pf;
            r[0] = sum_products(pa * m[0], pb * m[3], 0);
            r[1] = sum_products(pa * m[1], pb * m[4], 0);
            r[2] = sum_products(pa * m[2], pb * m[5], pc);
            r[3] = sum_products(pd * m[0], pe * m[3], 0);
            r[4] = sum_products(pd * m[1], pe * m[4], 0);
            r[5] = sum_products(pd * m[2], pe * m[5], pf);
            for (int i = 0; i < 6; i++) begin
                m[i] = clip32(r[i], flag);
            end
        end
        for (int i = 0; i < 6; i++) begin
            res.m[i] = m[i][31:0];
        end
        res.sat = flag;
        return res;
    endfunction

    function automatic logic signed [31:0] rand32();
        case ($urandom_range(0, 9))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return $signed(32'($urandom_range(0, 32'h0004_0000))) - 32'sh0002_0000;
            3, 4, 5: return $signed(32'($urandom_range(0, 32'h0010_0000))) - 32'sh0008_0000;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic t_xform random_xform();
        t_xform x;
        x.scale_x = rand32(); x.scale_y = rand32();
        x.angle = $urandom_range(0, 3) == 0 ? 16'(23040 * $urandom_range(0, 2) - 23040 +
                  2880 * $urandom_range(0, 8)) : 16'($urandom());
        x.trans_x = rand32(); x.trans_y = rand32();
        x.use_parent = $urandom_range(0, 1);
        x.pa = rand32(); x.pb = rand32(); x.pc = rand32();
        x.pd = rand32(); x.pe = rand32(); x.pf = rand32();
        return x;
    endfunction

    function automatic t_xform plain_xform(logic signed [31:0] sx, logic signed [31:0] sy,
                                           logic signed [15:0] ang);
        t_xform x;
        x.scale_x = sx; x.scale_y = sy; x.angle = ang;
        x.trans_x = 32'sh0001_0000; x.trans_y = -32'sh0002_0000;
        x.use_parent = 1'b0;
        x.pa = '0; x.pb = '0; x.pc = '0; x.pd = '0; x.pe = '0; x.pf = '0;
        return x;
    endfunction

    function automatic t_matrix literal_matrix(logic signed [31:0] a, logic signed [31:0] b,
                                               logic signed [31:0] c, logic signed [31:0] d,
                                               logic signed [31:0] e, logic signed [31:0] f,
                                               logic sat);
        t_matrix r;
        r.m = '{a, b, c, d, e, f};
        r.sat = sat;
        return r;
    endfunction

    task automatic send_beat(t_xform x, t_matrix want);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_scale_x <= x.scale_x; i_scale_y <= x.scale_y; i_angle <= x.angle;
        i_trans_x <= x.trans_x; i_trans_y <= x.trans_y; i_use_parent <= x.use_parent;
        i_parent_a <= x.pa; i_parent_b <= x.pb; i_parent_c <= x.pc;
        i_parent_d <= x.pd; i_parent_e <= x.pe; i_parent_f <= x.pf;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_matrices.push_back(want);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_stall <= (recv_idle_pct > 0) && ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_matrix want;
        logic signed [31:0] got [6];
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_out_a, o_out_b, o_out_c, o_out_d, o_out_e, o_out_f};
            if (pending_matrices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output beat");
            end else begin
                want = pending_matrices.pop_front();
                for (int i = 0; i < 6; i++) begin
                    if (got[i] !== want.m[i]) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("entry %0d: expected %0d got %0d", i, want.m[i], got[i]);
                        end
                    end
                end
                if (o_saturated !== want.sat) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("saturated: expected %0b got %0b", want.sat, o_saturated);
                    end
                end
            end
        end
    end

    initial begin
        #50ms;
        $display("affine_trs_matrix_compose_unit_test: errors");
        $finish;
    end

    initial begin
        t_vector_row vectors [N_DIRECTED];
        t_xform x;
        int drain;
        // Identity, right angles, full-turn wrap, negative angles, extreme scales and parent composition.
        vectors[0] = '{plain_xform(32'sh0001_0000, 32'sh0001_0000, 16'sd0), 1'b1,
            literal_matrix(32'sh0001_0000, 0, 32'sh0001_0000, 0, 32'sh0001_0000,
                           -32'sh0002_0000, 1'b0)};
        vectors[1] = '{plain_xform(32'sh0001_0000, 32'sh0001_0000, 16'sd5760), 1'b1,
            literal_matrix(0, -32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 0,
                           -32'sh0002_0000, 1'b0)};
        vectors[2] = '{plain_xform(32'sh0001_0000, 32'sh0001_0000, 16'sd23040), 1'b1,
            literal_matrix(32'sh0001_0000, 0, 32'sh0001_0000, 0, 32'sh0001_0000,
                           -32'sh0002_0000, 1'b0)};
        vectors[3] = '{plain_xform(32'sh0001_0000, 32'sh0001_0000, -16'sd5760), 1'b1,
            literal_matrix(0, 32'sh0001_0000, 32'sh0001_0000, -32'sh0001_0000, 0,
                           -32'sh0002_0000, 1'b0)};
        vectors[4] = '{plain_xform(32'sh7fff_ffff, 32'sh8000_0000, 16'sd11520), 1'b1,
            literal_matrix(-32'sh7fff_ffff, 0, 32'sh0001_0000, 0, 32'sh7fff_ffff,
                           -32'sh0002_0000, 1'b1)};
        vectors[5] = '{plain_xform(32'sh8000_0000, 32'sh7fff_ffff, 16'sd2880), 1'b0, '{default: 0}};
        vectors[6] = '{plain_xform(32'sh7fff_ffff, 32'sh7fff_ffff, 16'sd32767), 1'b0, '{default: 0}};
        vectors[7] = '{plain_xform(32'sh8000_0000, 32'sh8000_0000, -16'sd32768), 1'b0, '{default: 0}};
        vectors[8] = '{plain_xform(32'sh0000_0001, -32'sh0000_0001, 16'sd2881), 1'b0, '{default: 0}};
        vectors[9] = '{plain_xform(32'sh0001_8000, 32'sh0000_8000, 16'sd17280), 1'b0, '{default: 0}};
        for (int i = 10; i < N_DIRECTED; i++) begin
            vectors[i].x = plain_xform(32'sh0002_0000, 32'sh0001_0000, 16'(1000 * i));
            vectors[i].x.use_parent = 1'b1;
            vectors[i].typed = 1'b0;
        end
        vectors[10].x.pa = 32'sh7fff_ffff; vectors[10].x.pb = 32'sh7fff_ffff;
        vectors[10].x.pc = 32'sh7fff_ffff; vectors[10].x.pd = 32'sh8000_0000;
        vectors[10].x.pe = 32'sh8000_0000; vectors[10].x.pf = 32'sh8000_0000;
        vectors[11].x.pa = 32'sh0001_0000; vectors[11].x.pe = 32'sh0001_0000;
        vectors[11].x.pc = 32'sh0003_0000; vectors[11].x.pf = -32'sh0004_0000;
        vectors[12].x.pa = -32'sh0000_0001; vectors[12].x.pb = 32'sh0000_8000;
        vectors[12].x.pd = 32'sh0001_0000; vectors[12].x.pe = -32'sh0000_0001;
        vectors[13].x.trans_x = 32'sh7fff_ffff; vectors[13].x.trans_y = 32'sh8000_0000;
        vectors[13].x.pa = 32'sh0010_0000; vectors[13].x.pe = 32'sh0010_0000;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_beat(vectors[i].x,
                      vectors[i].typed ? vectors[i].want : compose_trs(vectors[i].x));
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 14 : (phase == 1 ? 81 : 0);
            recv_idle_pct = phase == 0 ? 81 : (phase == 1 ? 14 : 0);
            for (int n = 0; n < N_RANDOM / 3; n++) begin
                x = random_xform();
                send_beat(x, compose_trs(x));
            end
        end
        i_valid <= 1'b0;
        recv_idle_pct = 20;

        drain = 0;
        while (pending_matrices.size() != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        recv_idle_pct = 0;
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && pending_matrices.size() == 0) begin
            $display("affine_trs_matrix_compose_unit_test: clean");
        end else begin
            $display("affine_trs_matrix_compose_unit_test: errors");
        end
        $finish;
    end
endmodule
